// ===== hdl/ackfr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ackfr_pkg
// Shared types and constants for the acknowledgement frame receiver.
// ---------------------------------------------------------------------------
package ackfr_pkg;

    // Commands on the input channel
    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_PROTOCOL = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    // Frame constants
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  SOF_A         = 8'hA5;
    localparam logic [7:0]  SOF_B         = 8'h5A;
    localparam logic [7:0]  ACK_TYPE      = 8'h81;
    localparam logic [7:0]  PROTO_VERSION = 8'h01;
    localparam logic [15:0] ACK_LENGTH    = 16'h0001;

    localparam int COUNT_W = 5;

    // Parser verdict for the byte being presented
    typedef struct packed {
        logic       done;
        logic [1:0] status;
        logic [7:0] code;
    } t_parse_res;

endpackage

// ===== hdl/ack_frame_receiver.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ack_frame_receiver
// Waits for one acknowledgement frame after an arm word and reports status.
// ---------------------------------------------------------------------------
// Path: an accepted word is held in the input register, processed from there,
//   and its result (if any) is presented from the output register.
// Throughput: one word per cycle unless stalled; the parser's byte-wide
//   CRC update and the tick compare each fit between input and output register.
// Reset: synchronous, active low; clears control state, timeout returns to 100.
module ack_frame_receiver #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_expected_sequence,
    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_remote_code,
    // configuration write channel (ack_timeout)
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    // --- configuration -------------------------------------------------------
    logic [15:0] r_ack_timeout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= 16'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ack_timeout <= i_cfg_data;
        end
    end

    // --- input register ------------------------------------------------------
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [7:0]  r_byte;
    logic [15:0] r_exp_seq;

    logic out_free;    // output register can take a result this cycle
    logic proc_fire;   // registered word is processed at this edge
    logic in_load;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign proc_fire  = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_load    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_cmd     <= i_cmd;
            r_byte    <= i_data_byte;
            r_exp_seq <= i_expected_sequence;
        end
    end

    // --- wait control --------------------------------------------------------
    logic        r_armed;
    logic [15:0] r_wanted_seq;
    logic [15:0] r_elapsed;

    logic [15:0] elapsed_inc;   // saturating tick count
    logic        timed_out;     // elapsed already at or past the limit
    logic        parse_clear;
    logic        parse_byte;
    ackfr_pkg::t_parse_res parse_res;

    logic        res_valid;
    logic [1:0]  res_status;
    logic [7:0]  res_code;

    assign elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign timed_out   = (r_elapsed >= r_ack_timeout);

    always_comb begin
        parse_clear = 1'b0;
        parse_byte  = 1'b0;
        res_valid   = 1'b0;
        res_status  = ackfr_pkg::ST_OK;
        res_code    = 8'h00;
        if (proc_fire) begin
            if (r_cmd == ackfr_pkg::CMD_ARM) begin
                // a re-arm restarts the wait; zero timeout answers at once
                parse_clear = 1'b1;
                if (r_ack_timeout == 16'd0) begin
                    res_valid  = 1'b1;
                    res_status = ackfr_pkg::ST_TIMEOUT;
                end
            end else if (r_armed && r_cmd == ackfr_pkg::CMD_TICK) begin
                if (elapsed_inc >= r_ack_timeout) begin
                    parse_clear = 1'b1;
                    res_valid   = 1'b1;
                    res_status  = ackfr_pkg::ST_TIMEOUT;
                end
            end else if (r_armed && r_cmd == ackfr_pkg::CMD_BYTE) begin
                // limit may have been lowered mid-wait
                if (timed_out) begin
                    parse_clear = 1'b1;
                    res_valid   = 1'b1;
                    res_status  = ackfr_pkg::ST_TIMEOUT;
                end else begin
                    parse_byte = 1'b1;
                    res_valid  = parse_res.done;
                    res_status = parse_res.status;
                    res_code   = parse_res.code;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_wanted_seq <= '0;
            r_elapsed    <= '0;
        end else if (proc_fire) begin
            if (r_cmd == ackfr_pkg::CMD_ARM) begin
                r_armed      <= (r_ack_timeout != 16'd0);
                r_wanted_seq <= r_exp_seq;
                r_elapsed    <= '0;
            end else begin
                if (r_armed && r_cmd == ackfr_pkg::CMD_TICK) begin
                    r_elapsed <= elapsed_inc;
                end
                if (res_valid) begin
                    r_armed <= 1'b0;
                end
            end
        end
    end

    ackfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_clear           (parse_clear),
        .i_byte_en         (parse_byte),
        .i_byte            (r_byte),
        .i_wanted_sequence (r_wanted_seq),
        .o_res             (parse_res)
    );

    // --- output register -----------------------------------------------------
    logic [1:0] r_status;
    logic [7:0] r_code;
    logic       r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && res_valid) begin
            r_status <= res_status;
            r_code   <= res_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_remote_code = r_code;

`ifndef SYNTHESIS
    // a nonzero remote code only comes with a rejection
    a_code_only_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_remote_code != 8'h00) |-> o_status == ackfr_pkg::ST_REJECTED)
        else $error("remote code without rejected status");

    // a rejection always carries its nonzero code
    a_rejected_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ackfr_pkg::ST_REJECTED) |-> o_remote_code != 8'h00)
        else $error("rejected status with zero code");

    // every result ends the wait
    a_result_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && res_valid |=> !r_armed)
        else $error("still armed after a result");

    // arm with a zero limit answers timeout on the next cycle
    a_zero_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && (r_cmd == ackfr_pkg::CMD_ARM) && (r_ack_timeout == 16'd0)
        |=> r_out_valid && (r_status == ackfr_pkg::ST_TIMEOUT))
        else $error("zero timeout did not answer at once");

    // input side only stalls while a word is held
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("stall without a held word");
`endif

endmodule

// ===== hdl/ackfr_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ackfr_parser
// Byte-wise frame parser: start hunt, header, payload, CRC and final check.
// ---------------------------------------------------------------------------
module ackfr_parser #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_byte_en,
    input  logic [7:0]            i_byte,
    input  logic [15:0]           i_wanted_sequence,
    output ackfr_pkg::t_parse_res o_res
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CRC     = 2'd3;

    localparam int CW = ackfr_pkg::COUNT_W;

    // MSB-first CRC-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ ackfr_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [1:0]    r_phase,   n_phase;
    logic          r_start,   n_start;
    logic [CW-1:0] r_count,   n_count;
    logic [7:0]    r_version, n_version;
    logic [7:0]    r_type,    n_type;
    logic [15:0]   r_seq,     n_seq;
    logic [15:0]   r_plen,    n_plen;
    logic [7:0]    r_first,   n_first;
    logic [15:0]   r_crc,     n_crc;
    logic [7:0]    r_rcrc,    n_rcrc;   // low CRC byte; the high one is checked on arrival

    logic [15:0]   crc_upd;
    logic [15:0]   count_inc;
    logic [15:0]   rcrc_full;
    logic          frame_bad;

    assign crc_upd   = crc_byte(r_crc, i_byte);
    assign count_inc = {{(16 - CW){1'b0}}, r_count} + 16'd1;
    assign rcrc_full = {i_byte, r_rcrc};
    assign frame_bad = (r_version != ackfr_pkg::PROTO_VERSION)
                    || (r_type != ackfr_pkg::ACK_TYPE)
                    || (r_seq != i_wanted_sequence)
                    || (r_plen != ackfr_pkg::ACK_LENGTH)
                    || (rcrc_full != r_crc);

    always_comb begin
        n_phase   = r_phase;
        n_start   = r_start;
        n_count   = r_count;
        n_version = r_version;
        n_type    = r_type;
        n_seq     = r_seq;
        n_plen    = r_plen;
        n_first   = r_first;
        n_crc     = r_crc;
        n_rcrc    = r_rcrc;
        o_res     = '0;

        unique case (r_phase)
            PH_HUNT: begin
                if (r_start && i_byte == ackfr_pkg::SOF_B) begin
                    n_start = 1'b0;
                    n_phase = PH_HEADER;
                    n_count = '0;
                    n_crc   = ackfr_pkg::CRC_INIT;
                end else begin
                    n_start = (i_byte == ackfr_pkg::SOF_A);
                end
            end
            PH_HEADER: begin
                n_crc = crc_upd;
                unique case (r_count)
                    CW'(0):  n_version = i_byte;
                    CW'(1):  n_type    = i_byte;
                    CW'(2):  n_seq     = {8'h00, i_byte};
                    CW'(3):  n_seq     = {i_byte, r_seq[7:0]};
                    CW'(4):  n_plen    = {8'h00, i_byte};
                    default: n_plen    = {i_byte, r_plen[7:0]};
                endcase
                if (r_count < CW'(5)) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_count = '0;
                    if (n_plen > 16'(MAX_PAYLOAD)) begin
                        o_res.done   = 1'b1;
                        o_res.status = ackfr_pkg::ST_PROTOCOL;
                    end else if (n_plen == 16'd0) begin
                        n_phase = PH_CRC;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_crc = crc_upd;
                if (r_count == '0) begin
                    n_first = i_byte;
                end
                if (count_inc >= r_plen) begin
                    n_count = '0;
                    n_phase = PH_CRC;
                end else begin
                    n_count = count_inc[CW-1:0];
                end
            end
            default: begin
                if (r_count == '0) begin
                    n_rcrc  = i_byte;
                    n_count = CW'(1);
                end else begin
                    o_res.done = 1'b1;
                    if (frame_bad) begin
                        o_res.status = ackfr_pkg::ST_PROTOCOL;
                    end else if (r_first == 8'h00) begin
                        o_res.status = ackfr_pkg::ST_OK;
                    end else begin
                        o_res.status = ackfr_pkg::ST_REJECTED;
                        o_res.code   = r_first;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear || (i_byte_en && o_res.done)) begin
            r_phase   <= PH_HUNT;
            r_start   <= 1'b0;
            r_count   <= '0;
            r_version <= '0;
            r_type    <= '0;
            r_seq     <= '0;
            r_plen    <= '0;
            r_first   <= '0;
            r_crc     <= ackfr_pkg::CRC_INIT;
            r_rcrc    <= '0;
        end else if (i_byte_en) begin
            r_phase   <= n_phase;
            r_start   <= n_start;
            r_count   <= n_count;
            r_version <= n_version;
            r_type    <= n_type;
            r_seq     <= n_seq;
            r_plen    <= n_plen;
            r_first   <= n_first;
            r_crc     <= n_crc;
            r_rcrc    <= n_rcrc;
        end
    end

endmodule
